// ===== rtl/wbv_pkg.sv =====
// ----------------------------------------------------------------------------
// Wavetable bass voice package
// Shared types, register indexes, sequencer states and helper functions.
// ----------------------------------------------------------------------------
package wbv_pkg;

  localparam int MUL_AW = 26;
  localparam int MUL_BW = 25;
  localparam int MUL_PW = MUL_AW + MUL_BW;
  localparam int MUL_CW = $clog2(MUL_BW + 1);
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 24;

  typedef logic signed [MUL_AW-1:0] mul_a_t;
  typedef logic [MUL_BW-1:0] mul_b_t;
  typedef logic signed [MUL_PW-1:0] mul_p_t;

  typedef enum logic [CFG_IW-1:0] {
    REG_TIMBRE = 3'd0,
    REG_PLUCK  = 3'd1,
    REG_TONE   = 3'd2,
    REG_DECAY  = 3'd3,
    REG_NOISE  = 3'd4,
    REG_RATE   = 3'd5
  } reg_idx_e;

  typedef enum logic [1:0] {
    PLUCK_FINGER = 2'd0,
    PLUCK_PICK   = 2'd1,
    PLUCK_SLAP   = 2'd2
  } pluck_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_STEP,
    ST_ONF,
    ST_ONH,
    ST_FUND,
    ST_HCOEF,
    ST_HDEC,
    ST_Z2,
    ST_T1,
    ST_T2,
    ST_SIN,
    ST_WGT,
    ST_INTERP,
    ST_HAMP,
    ST_MIX,
    ST_LFSR,
    ST_ENV,
    ST_N1,
    ST_N2,
    ST_N3,
    ST_TONE,
    ST_LP,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic        timbre_select;
    logic [1:0]  pluck_style;
    logic [15:0] tone_amount;
    logic [15:0] decay_amount;
    logic [15:0] noise_amount;
    logic [23:0] inv_rate;
  } cfg_t;

  typedef struct packed {
    logic [22:0] freq_hz;
    logic [15:0] note_velocity;
    logic        gate;
    logic [15:0] since_onset;
  } item_t;

  typedef struct packed {
    logic idle;
    logic res_valid;
  } core_sts_t;

  function automatic logic [15:0] cap15(logic [15:0] v);
    return (v > 16'd32768) ? 16'd32768 : v;
  endfunction

  function automatic mul_p_t rnd_shr(mul_p_t v, int unsigned s);
    mul_p_t half;
    half = mul_p_t'(1) <<< (s - 1);
    return (v + half) >>> s;
  endfunction

endpackage

// ===== rtl/wbv_mul.sv =====
// ----------------------------------------------------------------------------
// Serial multiplier
// Signed by unsigned shift-add multiplier retiring one multiplier bit a cycle.
// ----------------------------------------------------------------------------
module wbv_mul (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  wbv_pkg::mul_a_t a_i,
  input  wbv_pkg::mul_b_t b_i,
  output logic            done_o,
  output wbv_pkg::mul_p_t prod_o
);

  wbv_pkg::mul_a_t             a_q;
  wbv_pkg::mul_p_t             prod_q, prod_d;
  logic [wbv_pkg::MUL_CW-1:0]  cnt_q;
  logic                        done_q;
  logic signed [wbv_pkg::MUL_AW:0] sum;

  always_comb begin
    sum = $signed({prod_q[wbv_pkg::MUL_PW-1], prod_q[wbv_pkg::MUL_PW-1:wbv_pkg::MUL_BW]});
    if (prod_q[0]) begin
      sum = sum + $signed({a_q[wbv_pkg::MUL_AW-1], a_q});
    end
    prod_d = {sum, prod_q[wbv_pkg::MUL_BW-1:1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == wbv_pkg::MUL_CW'(1));
      if (start_i) begin
        cnt_q <= wbv_pkg::MUL_CW'(wbv_pkg::MUL_BW);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q    <= a_i;
      prod_q <= {{wbv_pkg::MUL_AW{1'b0}}, b_i};
    end else if (cnt_q != '0) begin
      prod_q <= prod_d;
    end
  end

  assign done_o = done_q;
  assign prod_o = prod_q;

endmodule

// ===== rtl/wbv_lfsr.sv =====
// ----------------------------------------------------------------------------
// Fret noise generator
// 32-bit Galois LFSR advanced sixteen single steps per request.
// ----------------------------------------------------------------------------
module wbv_lfsr (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        done_o,
  output logic [15:0] noise_o
);

  localparam logic [31:0] Seed = 32'h2545_F491;
  localparam logic [31:0] Mask = 32'h8020_0003;

  logic [31:0] lfsr_q, lfsr_d;
  logic [4:0]  cnt_q;
  logic        done_q;

  always_comb begin
    lfsr_d = {1'b0, lfsr_q[31:1]};
    if (lfsr_q[0]) begin
      lfsr_d = lfsr_d ^ Mask;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfsr_q <= Seed;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == 5'd1);
      if (start_i) begin
        cnt_q <= 5'd16;
      end else if (cnt_q != '0) begin
        cnt_q  <= cnt_q - 1'b1;
        lfsr_q <= lfsr_d;
      end
    end
  end

  assign done_o  = done_q;
  assign noise_o = lfsr_q[15:0];

endmodule

// ===== rtl/wbv_div.sv =====
// ----------------------------------------------------------------------------
// Noise envelope divider
// Restoring division of d * 32768 by the constant span, one bit a cycle.
// ----------------------------------------------------------------------------
module wbv_div #(
  parameter int Divisor = 100
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [$clog2(Divisor + 1)-1:0]   num_i,
  output logic                             done_o,
  output logic [15:0]                      quo_o
);

  localparam int SPW = $clog2(Divisor + 1);
  localparam int NW  = SPW + 15;
  localparam int CW  = $clog2(NW + 1);

  logic [NW-1:0]  num_q;
  logic [SPW-1:0] rem_q;
  logic [15:0]    quo_q;
  logic [CW-1:0]  cnt_q;
  logic           done_q;
  logic [SPW:0]   trial;
  logic           fits;

  assign trial = {rem_q, num_q[NW-1]};
  assign fits  = (trial >= (SPW + 1)'(Divisor));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == CW'(1));
      if (start_i) begin
        cnt_q <= CW'(NW);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= {num_i, 15'd0};
      rem_q <= '0;
      quo_q <= '0;
    end else if (cnt_q != '0) begin
      num_q <= {num_q[NW-2:0], 1'b0};
      rem_q <= fits ? SPW'(trial - (SPW + 1)'(Divisor)) : trial[SPW-1:0];
      quo_q <= {quo_q[14:0], fits};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ===== rtl/wbv_core.sv =====
// ----------------------------------------------------------------------------
// Voice sequencer
// Steps one sample through phase, envelopes, table synthesis, noise and filter
// on a shared serial multiplier. TABLE_SIZE must be a power of two.
// ----------------------------------------------------------------------------
module wbv_core #(
  parameter int TABLE_SIZE = 2048,
  parameter int NOISE_SPAN = 100
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  wbv_pkg::cfg_t            cfg_i,
  input  wbv_pkg::item_t           item_i,
  input  logic                     out_free_i,
  output wbv_pkg::core_sts_t       sts_o,
  output logic signed [16:0]       audio_o
);

  localparam int IDXW = $clog2(TABLE_SIZE);
  localparam int QPAD = 16 - IDXW;
  localparam int SPW  = $clog2(NOISE_SPAN + 1);
  localparam logic [2:0] LastHarm = 3'd5;

  wbv_pkg::state_e state_q, state_d;
  logic            iss_q, iss_d;

  logic [23:0]        phase_q;
  logic [17:0]        fund_q, harm_q;
  logic [15:0]        target_q;
  logic signed [17:0] lp_q;

  logic [23:0]        step_q, hcoef_q;
  logic               sel_q;
  logic [2:0]         h_q;
  logic [IDXW-1:0]    arg_q;
  logic [14:0]        z2_q, t_q;
  logic signed [16:0] s_q, w_q, n_q;
  logic signed [33:0] acc_q;
  logic signed [15:0] ea_q, eb_q;
  logic [18:0]        amp_q;
  logic signed [19:0] x_q;
  logic [15:0]        c_q;

  wbv_pkg::mul_a_t mul_a;
  wbv_pkg::mul_b_t mul_b;
  wbv_pkg::mul_p_t p;
  logic            mul_start, mul_done;
  logic            lfsr_start, lfsr_done;
  logic            div_start, div_done;
  logic [15:0]     noise, env;
  logic            res_valid;

  logic [15:0]        vel, amt;
  logic               onset, pluck_ok, noise_on;
  logic [IDXW+23:0]   pos;
  logic [IDXW-1:0]    idx, nxt, karg;
  logic [15:0]        frac, q16;
  logic [14:0]        z;
  logic [SPW-1:0]     span_d;
  logic signed [19:0] diff;
  logic signed [16:0] ediff;
  logic signed [20:0] lpd;
  wbv_pkg::mul_p_t    fsum, lps, r14, r15, r16;
  logic [15:0]        smag;
  logic signed [33:0] acc_new, racc;
  logic signed [15:0] entry;

  function automatic logic [15:0] pluck_k(logic [1:0] style, logic harm);
    logic [15:0] k;
    unique case (style)
      wbv_pkg::PLUCK_FINGER: k = harm ? 16'd22938 : 16'd9830;
      wbv_pkg::PLUCK_PICK:   k = harm ? 16'd32768 : 16'd13107;
      wbv_pkg::PLUCK_SLAP:   k = harm ? 16'd42598 : 16'd16384;
      default:               k = 16'd0;
    endcase
    return k;
  endfunction

  function automatic logic [14:0] harm_weight(logic tsel, logic [2:0] h);
    logic [14:0] wt;
    unique case ({tsel, h})
      4'b0_000: wt = 15'd14247;
      4'b0_001: wt = 15'd5699;
      4'b0_010: wt = 15'd4274;
      4'b0_011: wt = 15'd3562;
      4'b0_100: wt = 15'd2849;
      4'b0_101: wt = 15'd2137;
      4'b1_000: wt = 15'd18725;
      4'b1_001: wt = 15'd5617;
      4'b1_010: wt = 15'd3745;
      4'b1_011: wt = 15'd2809;
      4'b1_100: wt = 15'd1872;
      default:  wt = 15'd0;
    endcase
    return wt;
  endfunction

  assign vel      = wbv_pkg::cap15(item_i.note_velocity);
  assign amt      = wbv_pkg::cap15(cfg_i.noise_amount);
  assign onset    = item_i.gate && (item_i.since_onset == 16'd0);
  assign pluck_ok = (cfg_i.pluck_style == wbv_pkg::PLUCK_FINGER) ||
                    (cfg_i.pluck_style == wbv_pkg::PLUCK_PICK) ||
                    (cfg_i.pluck_style == wbv_pkg::PLUCK_SLAP);
  assign noise_on = (amt != 16'd0) && (item_i.since_onset < 16'(NOISE_SPAN));
  assign span_d   = SPW'(NOISE_SPAN) - item_i.since_onset[SPW-1:0];

  assign pos  = {phase_q, {IDXW{1'b0}}};
  assign idx  = pos[IDXW+23:24];
  assign frac = pos[23:8];
  assign nxt  = idx + 1'b1;
  assign karg = sel_q ? nxt : idx;
  assign q16  = {arg_q, {QPAD{1'b0}}};
  assign z    = q16[14] ? (15'd16384 - {1'b0, q16[13:0]}) : {1'b0, q16[13:0]};

  assign diff  = $signed({3'b000, target_q, 1'b0}) - $signed({2'b00, fund_q});
  assign ediff = $signed({eb_q[15], eb_q}) - $signed({ea_q[15], ea_q});
  assign lpd   = $signed({x_q[19], x_q}) - $signed({{3{lp_q[17]}}, lp_q});

  assign r14  = wbv_pkg::rnd_shr(p, 14);
  assign r15  = wbv_pkg::rnd_shr(p, 15);
  assign r16  = wbv_pkg::rnd_shr(p, 16);
  assign fsum = wbv_pkg::mul_p_t'($signed({1'b0, fund_q})) + wbv_pkg::rnd_shr(p, 22);
  assign lps  = wbv_pkg::mul_p_t'(lp_q) + r15;
  assign smag = (p[28:13] > 16'd32768) ? 16'd32768 : p[28:13];

  assign acc_new = acc_q + $signed(p[33:0]);
  assign racc    = (acc_new + 34'sd16384) >>> 15;
  assign entry   = (racc > 34'sd32767) ? 16'sh7FFF :
                   (racc < -34'sd32768) ? 16'sh8000 : racc[15:0];

  wbv_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (p)
  );

  wbv_lfsr u_lfsr (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (lfsr_start),
    .done_o  (lfsr_done),
    .noise_o (noise)
  );

  wbv_div #(
    .Divisor (NOISE_SPAN)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (span_d),
    .done_o  (div_done),
    .quo_o   (env)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      wbv_pkg::ST_IDLE:   if (start_i) state_d = wbv_pkg::ST_STEP;
      wbv_pkg::ST_STEP: begin
        if (mul_done) state_d = (onset && pluck_ok) ? wbv_pkg::ST_ONF : wbv_pkg::ST_FUND;
      end
      wbv_pkg::ST_ONF:    if (mul_done) state_d = wbv_pkg::ST_ONH;
      wbv_pkg::ST_ONH:    if (mul_done) state_d = wbv_pkg::ST_FUND;
      wbv_pkg::ST_FUND:   if (mul_done) state_d = wbv_pkg::ST_HCOEF;
      wbv_pkg::ST_HCOEF:  if (mul_done) state_d = wbv_pkg::ST_HDEC;
      wbv_pkg::ST_HDEC:   if (mul_done) state_d = wbv_pkg::ST_Z2;
      wbv_pkg::ST_Z2:     if (mul_done) state_d = wbv_pkg::ST_T1;
      wbv_pkg::ST_T1:     if (mul_done) state_d = wbv_pkg::ST_T2;
      wbv_pkg::ST_T2:     if (mul_done) state_d = wbv_pkg::ST_SIN;
      wbv_pkg::ST_SIN:    if (mul_done) state_d = wbv_pkg::ST_WGT;
      wbv_pkg::ST_WGT: begin
        if (mul_done) begin
          state_d = (sel_q && (h_q == LastHarm)) ? wbv_pkg::ST_INTERP : wbv_pkg::ST_Z2;
        end
      end
      wbv_pkg::ST_INTERP: if (mul_done) state_d = wbv_pkg::ST_HAMP;
      wbv_pkg::ST_HAMP:   if (mul_done) state_d = wbv_pkg::ST_MIX;
      wbv_pkg::ST_MIX: begin
        if (mul_done) state_d = noise_on ? wbv_pkg::ST_LFSR : wbv_pkg::ST_TONE;
      end
      wbv_pkg::ST_LFSR:   if (lfsr_done) state_d = wbv_pkg::ST_ENV;
      wbv_pkg::ST_ENV:    if (div_done) state_d = wbv_pkg::ST_N1;
      wbv_pkg::ST_N1:     if (mul_done) state_d = wbv_pkg::ST_N2;
      wbv_pkg::ST_N2:     if (mul_done) state_d = wbv_pkg::ST_N3;
      wbv_pkg::ST_N3:     if (mul_done) state_d = wbv_pkg::ST_TONE;
      wbv_pkg::ST_TONE:   if (mul_done) state_d = wbv_pkg::ST_LP;
      wbv_pkg::ST_LP:     if (mul_done) state_d = wbv_pkg::ST_DONE;
      wbv_pkg::ST_DONE:   if (out_free_i) state_d = wbv_pkg::ST_IDLE;
      default:            state_d = wbv_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    mul_a      = '0;
    mul_b      = '0;
    mul_start  = 1'b0;
    lfsr_start = 1'b0;
    div_start  = 1'b0;
    res_valid  = 1'b0;
    unique case (state_q)
      wbv_pkg::ST_IDLE: begin
      end
      wbv_pkg::ST_STEP: begin
        mul_a = wbv_pkg::mul_a_t'(item_i.freq_hz);
        mul_b = wbv_pkg::mul_b_t'(cfg_i.inv_rate);
        mul_start = !iss_q;
      end
      wbv_pkg::ST_ONF: begin
        mul_a = wbv_pkg::mul_a_t'(vel);
        mul_b = wbv_pkg::mul_b_t'(pluck_k(cfg_i.pluck_style, 1'b0));
        mul_start = !iss_q;
      end
      wbv_pkg::ST_ONH: begin
        mul_a = wbv_pkg::mul_a_t'(vel);
        mul_b = wbv_pkg::mul_b_t'(pluck_k(cfg_i.pluck_style, 1'b1));
        mul_start = !iss_q;
      end
      wbv_pkg::ST_FUND: begin
        if (item_i.gate) begin
          mul_a = wbv_pkg::mul_a_t'(diff);
          mul_b = wbv_pkg::mul_b_t'(4194);
        end else begin
          mul_a = wbv_pkg::mul_a_t'(fund_q);
          mul_b = wbv_pkg::mul_b_t'(16775538);
        end
        mul_start = !iss_q;
      end
      wbv_pkg::ST_HCOEF: begin
        mul_a = wbv_pkg::mul_a_t'(wbv_pkg::cap15(cfg_i.decay_amount));
        mul_b = wbv_pkg::mul_b_t'(50332);
        mul_start = !iss_q;
      end
      wbv_pkg::ST_HDEC: begin
        mul_a = wbv_pkg::mul_a_t'(harm_q);
        mul_b = wbv_pkg::mul_b_t'(hcoef_q);
        mul_start = !iss_q;
      end
      wbv_pkg::ST_Z2: begin
        mul_a = wbv_pkg::mul_a_t'(z);
        mul_b = wbv_pkg::mul_b_t'(z);
        mul_start = !iss_q;
      end
      wbv_pkg::ST_T1: begin
        mul_a = wbv_pkg::mul_a_t'(z2_q);
        mul_b = wbv_pkg::mul_b_t'(1160);
        mul_start = !iss_q;
      end
      wbv_pkg::ST_T2: begin
        mul_a = wbv_pkg::mul_a_t'(z2_q);
        mul_b = wbv_pkg::mul_b_t'(t_q);
        mul_start = !iss_q;
      end
      wbv_pkg::ST_SIN: begin
        mul_a = wbv_pkg::mul_a_t'(z);
        mul_b = wbv_pkg::mul_b_t'(t_q);
        mul_start = !iss_q;
      end
      wbv_pkg::ST_WGT: begin
        mul_a = wbv_pkg::mul_a_t'(s_q);
        mul_b = wbv_pkg::mul_b_t'(harm_weight(cfg_i.timbre_select, h_q));
        mul_start = !iss_q;
      end
      wbv_pkg::ST_INTERP: begin
        mul_a = wbv_pkg::mul_a_t'(ediff);
        mul_b = wbv_pkg::mul_b_t'(frac);
        mul_start = !iss_q;
      end
      wbv_pkg::ST_HAMP: begin
        mul_a = wbv_pkg::mul_a_t'(harm_q);
        mul_b = wbv_pkg::mul_b_t'(45875);
        mul_start = !iss_q;
      end
      wbv_pkg::ST_MIX: begin
        mul_a = wbv_pkg::mul_a_t'(w_q);
        mul_b = wbv_pkg::mul_b_t'(amp_q);
        mul_start = !iss_q;
      end
      wbv_pkg::ST_LFSR: begin
        lfsr_start = !iss_q;
      end
      wbv_pkg::ST_ENV: begin
        div_start = !iss_q;
      end
      wbv_pkg::ST_N1: begin
        mul_a = wbv_pkg::mul_a_t'(n_q);
        mul_b = wbv_pkg::mul_b_t'(env);
        mul_start = !iss_q;
      end
      wbv_pkg::ST_N2: begin
        mul_a = wbv_pkg::mul_a_t'(n_q);
        mul_b = wbv_pkg::mul_b_t'(amt);
        mul_start = !iss_q;
      end
      wbv_pkg::ST_N3: begin
        mul_a = wbv_pkg::mul_a_t'(n_q);
        mul_b = wbv_pkg::mul_b_t'(6554);
        mul_start = !iss_q;
      end
      wbv_pkg::ST_TONE: begin
        mul_a = wbv_pkg::mul_a_t'(wbv_pkg::cap15(cfg_i.tone_amount));
        mul_b = wbv_pkg::mul_b_t'(26214);
        mul_start = !iss_q;
      end
      wbv_pkg::ST_LP: begin
        mul_a = wbv_pkg::mul_a_t'(lpd);
        mul_b = wbv_pkg::mul_b_t'(c_q);
        mul_start = !iss_q;
      end
      wbv_pkg::ST_DONE: begin
        res_valid = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign iss_d = (state_d != state_q) ? 1'b0 : (iss_q | mul_start | lfsr_start | div_start);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= wbv_pkg::ST_IDLE;
      iss_q    <= 1'b0;
      phase_q  <= '0;
      fund_q   <= '0;
      harm_q   <= '0;
      target_q <= '0;
      lp_q     <= '0;
    end else begin
      state_q <= state_d;
      iss_q   <= iss_d;
      if (mul_done) begin
        unique case (state_q)
          wbv_pkg::ST_STEP: begin
            if (onset) target_q <= vel;
          end
          wbv_pkg::ST_ONF: fund_q <= r14[17:0];
          wbv_pkg::ST_ONH: harm_q <= r14[17:0];
          wbv_pkg::ST_FUND: begin
            if (!item_i.gate) begin
              fund_q <= p[41:24];
            end else if (fsum < wbv_pkg::mul_p_t'(0)) begin
              fund_q <= '0;
            end else if (fsum > wbv_pkg::mul_p_t'(262143)) begin
              fund_q <= 18'h3FFFF;
            end else begin
              fund_q <= fsum[17:0];
            end
          end
          wbv_pkg::ST_HDEC:   harm_q  <= p[41:24];
          wbv_pkg::ST_INTERP: phase_q <= phase_q + step_q;
          wbv_pkg::ST_LP: begin
            if (lps < wbv_pkg::mul_p_t'(-131072)) begin
              lp_q <= 18'sh20000;
            end else if (lps > wbv_pkg::mul_p_t'(131071)) begin
              lp_q <= 18'sh1FFFF;
            end else begin
              lp_q <= lps[17:0];
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (lfsr_done && (state_q == wbv_pkg::ST_LFSR)) begin
      n_q <= $signed({noise[15], noise});
    end
    if (mul_done) begin
      unique case (state_q)
        wbv_pkg::ST_STEP:  step_q  <= p[35:12];
        wbv_pkg::ST_HCOEF: hcoef_q <= 24'd16710107 + 24'(p[30:15]);
        wbv_pkg::ST_HDEC: begin
          sel_q <= 1'b0;
          h_q   <= '0;
          arg_q <= idx;
          acc_q <= '0;
        end
        wbv_pkg::ST_Z2: z2_q <= p[28:14];
        wbv_pkg::ST_T1: t_q  <= 15'd10512 - p[28:14];
        wbv_pkg::ST_T2: t_q  <= 15'd25736 - p[28:14];
        wbv_pkg::ST_SIN: begin
          s_q <= q16[15] ? -$signed({1'b0, smag}) : $signed({1'b0, smag});
        end
        wbv_pkg::ST_WGT: begin
          if (h_q == LastHarm) begin
            if (sel_q) begin
              eb_q <= entry;
            end else begin
              ea_q <= entry;
            end
            sel_q <= 1'b1;
            h_q   <= '0;
            arg_q <= nxt;
            acc_q <= '0;
          end else begin
            h_q   <= h_q + 1'b1;
            arg_q <= arg_q + karg;
            acc_q <= acc_new;
          end
        end
        wbv_pkg::ST_INTERP: w_q   <= $signed({ea_q[15], ea_q}) + r16[16:0];
        wbv_pkg::ST_HAMP:   amp_q <= {1'b0, fund_q} + 19'(r16[15:0]);
        wbv_pkg::ST_MIX:    x_q   <= r16[19:0];
        wbv_pkg::ST_N1:     n_q   <= r15[16:0];
        wbv_pkg::ST_N2:     n_q   <= r15[16:0];
        wbv_pkg::ST_N3:     x_q   <= x_q + r15[19:0];
        wbv_pkg::ST_TONE:   c_q   <= 16'd6554 + r15[15:0];
        default: begin
        end
      endcase
    end
  end

  assign sts_o.idle      = (state_q == wbv_pkg::ST_IDLE);
  assign sts_o.res_valid = res_valid;
  assign audio_o = (lp_q > 18'sd65535) ? 17'sh0FFFF :
                   (lp_q < -18'sd65536) ? 17'sh10000 : lp_q[16:0];

endmodule

// ===== rtl/wavetable_bass_voice.sv =====
// ----------------------------------------------------------------------------
// Wavetable bass voice
// One filtered, saturated audio sample for every note state transaction.
// ----------------------------------------------------------------------------
// The input channel carries frequency, velocity, gate and samples since onset;
// each accepted transaction produces exactly one audio_out transaction.
// Settings are written through the configuration channel, which is always
// ready; index i selects the i-th setting and unknown indexes are ignored.
// A sample is computed by one serial multiplier that retires one bit per
// cycle. A sample needs 69 to 74 products (60 of them synthesize the two
// table entries harmonic by harmonic), plus noise stepping and a bit-serial
// envelope division when fret noise is active. A new input is taken once the
// previous sample has been handed to the output register.
// Reset restores the settings defaults, clears phase, levels and filter,
// and reseeds the noise generator; no clearing pass is needed.
// When the receiver stalls, the finished sample waits in the output
// register while the next sample is computed; that one then waits in turn.
// ----------------------------------------------------------------------------
module wavetable_bass_voice #(
  parameter int TABLE_SIZE = 2048,
  parameter int NOISE_SPAN = 100
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [wbv_pkg::CFG_IW-1:0]         cfg_index_i,
  input  logic [wbv_pkg::CFG_DW-1:0]         cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [22:0]                        freq_hz_i,
  input  logic [15:0]                        note_velocity_i,
  input  logic                               gate_i,
  input  logic [15:0]                        since_onset_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [16:0]                 audio_out_o
);

  wbv_pkg::cfg_t      cfg_q;
  wbv_pkg::item_t     item_q;
  wbv_pkg::core_sts_t sts;
  logic               go_q;
  logic               out_valid_q;
  logic signed [16:0] audio_q, core_audio;
  logic               in_acc, out_free;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = sts.idle && !go_q;
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timbre_select <= 1'b0;
      cfg_q.pluck_style   <= 2'd0;
      cfg_q.tone_amount   <= 16'd16384;
      cfg_q.decay_amount  <= 16'd16384;
      cfg_q.noise_amount  <= 16'd0;
      cfg_q.inv_rate      <= 24'd5825;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        wbv_pkg::REG_TIMBRE: cfg_q.timbre_select <= cfg_data_i[0];
        wbv_pkg::REG_PLUCK:  cfg_q.pluck_style   <= cfg_data_i[1:0];
        wbv_pkg::REG_TONE:   cfg_q.tone_amount   <= cfg_data_i[15:0];
        wbv_pkg::REG_DECAY:  cfg_q.decay_amount  <= cfg_data_i[15:0];
        wbv_pkg::REG_NOISE:  cfg_q.noise_amount  <= cfg_data_i[15:0];
        wbv_pkg::REG_RATE:   cfg_q.inv_rate      <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      go_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      go_q <= in_acc;
      if (sts.res_valid && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q.freq_hz       <= freq_hz_i;
      item_q.note_velocity <= note_velocity_i;
      item_q.gate          <= gate_i;
      item_q.since_onset   <= since_onset_i;
    end
    if (sts.res_valid && out_free) begin
      audio_q <= core_audio;
    end
  end

  wbv_core #(
    .TABLE_SIZE (TABLE_SIZE),
    .NOISE_SPAN (NOISE_SPAN)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (go_q),
    .cfg_i      (cfg_q),
    .item_i     (item_q),
    .out_free_i (out_free),
    .sts_o      (sts),
    .audio_o    (core_audio)
  );

  assign out_valid_o = out_valid_q;
  assign audio_out_o = audio_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o)
    else $error("input taken while a sample was in progress");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go_q |-> sts.idle && !in_ready_o)
    else $error("sequencer start while not idle");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sts.res_valid && out_valid_o && !out_ready_i) |=> sts.res_valid)
    else $error("finished sample dropped while output stalled");

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Wavetable bass voice testbench
// Drives note state transactions and settings into the voice, predicts every
// audio sample with an independent fixed-point model of the oscillator,
// envelopes, fret noise and low-pass filter, and compares each result in order.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_N = 2048;
  localparam int NOISE_N = 100;

  class voice_scoreboard;
    logic signed [15:0] wave_rom[2*TABLE_N];
    bit        timbre;
    bit [1:0]  style;
    bit [15:0] tone, decay, noise_lvl;
    bit [23:0] inv_rate;
    bit [23:0] phase;
    bit [31:0] lfsr;
    longint    fund, harm, target, lp;
    logic signed [16:0] sample_q[$];
    int        errors;
    int        checked;

    function new();
      int wt[2][6];
      longint acc;
      wt = '{'{14247, 5699, 4274, 3562, 2849, 2137}, '{18725, 5617, 3745, 2809, 1872, 0}};
      for (int tb = 0; tb < 2; tb++) begin
        for (int i = 0; i < TABLE_N; i++) begin
          acc = 0;
          for (int h = 1; h <= 6; h++) acc += wt[tb][h-1] * sine_q((h * i) % TABLE_N);
          wave_rom[tb*TABLE_N + i] = 16'(clip(rnd(acc, 15), -32768, 32767));
        end
      end
      timbre = 0; style = wbv_pkg::PLUCK_FINGER; tone = 16384; decay = 16384;
      noise_lvl = 0; inv_rate = 5825;
      phase = 0; fund = 0; harm = 0; target = 0; lp = 0;
      lfsr = 32'h2545F491;
      errors = 0; checked = 0;
    endfunction

    function longint rnd(longint v, int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function longint sat15(bit [15:0] v);
      return (v > 16'd32768) ? 32768 : longint'(v);
    endfunction

    function longint sine_q(int k);
      longint q, quad, z, z2, t, s;
      q = (longint'(k) << 16) / TABLE_N;
      quad = (q >> 14) & 3;
      z = q & 16383;
      if (quad & 1) z = 16384 - z;
      z2 = (z * z) >>> 14;
      t = 10512 - ((1160 * z2) >>> 14);
      t = 25736 - ((z2 * t) >>> 14);
      s = (z * t) >>> 13;
      if (s > 32768) s = 32768;
      return (quad & 2) ? -s : s;
    endfunction

    function void write_setting(wbv_pkg::reg_idx_e idx, bit [23:0] data);
      case (idx)
        wbv_pkg::REG_TIMBRE: timbre = data[0];
        wbv_pkg::REG_PLUCK:  style = data[1:0];
        wbv_pkg::REG_TONE:   tone = data[15:0];
        wbv_pkg::REG_DECAY:  decay = data[15:0];
        wbv_pkg::REG_NOISE:  noise_lvl = data[15:0];
        wbv_pkg::REG_RATE:   inv_rate = data;
        default: ;
      endcase
    endfunction

    function void note_input(bit [22:0] freq, bit [15:0] vel_raw, bit gate, bit [15:0] since);
      longint vel, stp, kf, kh, diff, hcoef, pos, idx, nxt, frac, a, b, w, amp, x;
      longint amt, n, env, c;
      vel = sat15(vel_raw);
      stp = ((longint'(freq) * inv_rate) >> 12) & 24'hFFFFFF;
      if (gate && since == 0) begin
        target = vel;
        kf = 0; kh = 0;
        case (style)
          wbv_pkg::PLUCK_FINGER: begin kf = 9830;  kh = 22938; end
          wbv_pkg::PLUCK_PICK:   begin kf = 13107; kh = 32768; end
          wbv_pkg::PLUCK_SLAP:   begin kf = 16384; kh = 42598; end
          default: ;
        endcase
        if (kf != 0) begin
          fund = (vel * kf + 8192) >> 14;
          harm = (vel * kh + 8192) >> 14;
        end
      end
      if (gate) begin
        diff = 2 * target - fund;
        fund = clip(fund + rnd(diff * 4194, 22), 0, 262143);
      end else begin
        fund = (fund * 16775538) >> 24;
      end
      hcoef = 16710107 + ((sat15(decay) * 50332) >> 15);
      harm = (harm * hcoef) >> 24;
      pos = longint'(phase) * TABLE_N;
      idx = pos >> 24;
      if (idx >= TABLE_N) idx = TABLE_N - 1;
      frac = (pos >> 8) & 16'hFFFF;
      nxt = (idx + 1 >= TABLE_N) ? 0 : idx + 1;
      a = wave_rom[timbre*TABLE_N + idx];
      b = wave_rom[timbre*TABLE_N + nxt];
      w = a + rnd((b - a) * frac, 16);
      phase = 24'(phase + stp);
      amp = fund + ((harm * 45875 + 32768) >> 16);
      x = rnd(w * amp, 16);
      amt = sat15(noise_lvl);
      if (amt > 0 && since < NOISE_N) begin
        for (int i = 0; i < 16; i++) begin
          if (lfsr[0]) lfsr = (lfsr >> 1) ^ 32'h80200003;
          else lfsr = lfsr >> 1;
        end
        n = longint'($signed(lfsr[15:0]));
        env = ((NOISE_N - longint'(since)) * 32768) / NOISE_N;
        n = rnd(n * env, 15);
        n = rnd(n * amt, 15);
        x += rnd(n * 6554, 15);
      end
      c = 6554 + rnd(sat15(tone) * 26214, 15);
      lp = clip(lp + rnd((x - lp) * c, 15), -131072, 131071);
      sample_q.push_back(17'(clip(lp, -65536, 65535)));
    endfunction

    task report(string what, longint got, longint want);
      errors++;
      $display("MISMATCH %s at sample %0d: got %0d expected %0d", what, checked, got, want);
    endtask

    task check_sample(logic signed [16:0] got);
      logic signed [16:0] want;
      if (sample_q.size() == 0) begin
        report("unexpected sample", got, 0);
      end else begin
        want = sample_q.pop_front();
        if (got !== want) report("audio_out", got, want);
      end
      checked++;
    endtask

    function int pending();
      return sample_q.size();
    endfunction
  endclass

  logic clk, rst_n;
  logic cfg_valid, cfg_ready;
  logic [wbv_pkg::CFG_IW-1:0] cfg_index;
  logic [wbv_pkg::CFG_DW-1:0] cfg_data;
  logic in_valid, in_ready;
  logic [22:0] freq_hz;
  logic [15:0] note_velocity, since_onset;
  logic gate;
  logic out_valid, out_ready;
  logic signed [16:0] audio_out;

  voice_scoreboard sb;
  int burst_left;
  int sent;
  int cyc;

  wavetable_bass_voice u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .freq_hz_i(freq_hz), .note_velocity_i(note_velocity),
    .gate_i(gate), .since_onset_i(since_onset),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .audio_out_o(audio_out)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #1000ms;
    $display("simulation failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_sample(audio_out);
  end

  // Receiver back-pressure cycles through free flow, random, sparse and long stalls.
  initial begin
    out_ready = 0;
    cyc = 0;
    forever begin
      @(negedge clk);
      cyc++;
      case ((cyc >> 13) % 4)
        0: out_ready <= 1;
        1: out_ready <= $urandom_range(0, 1);
        2: out_ready <= (cyc % 8) == 0;
        default: out_ready <= (cyc % 3000) < 10;
      endcase
    end
  end

  task write_reg(wbv_pkg::reg_idx_e idx, bit [23:0] data);
    @(negedge clk);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= data;
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    sb.write_setting(idx, data);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task write_all(bit t, bit [1:0] p, bit [15:0] tn, bit [15:0] dc, bit [15:0] nz,
                 bit [23:0] rate);
    write_reg(wbv_pkg::REG_TIMBRE, 24'(t));
    write_reg(wbv_pkg::REG_PLUCK, 24'(p));
    write_reg(wbv_pkg::REG_TONE, 24'(tn));
    write_reg(wbv_pkg::REG_DECAY, 24'(dc));
    write_reg(wbv_pkg::REG_NOISE, 24'(nz));
    write_reg(wbv_pkg::REG_RATE, rate);
  endtask

  task send_item(bit [22:0] f, bit [15:0] v, bit g, bit [15:0] s);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2500) : $urandom_range(0, 30);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1; freq_hz <= f; note_velocity <= v; gate <= g; since_onset <= s;
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    sb.note_input(f, v, g, s);
    sent++;
  endtask

  task drain();
    @(negedge clk);
    in_valid <= 0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task play_note(int hold, int rel);
    bit [22:0] f;
    bit [15:0] v;
    int s;
    f = ($urandom_range(0, 5) == 0) ? 23'($urandom) : 23'($urandom_range(30 << 8, 500 << 8));
    v = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768));
    s = 0;
    for (int i = 0; i < hold + rel; i++) begin
      send_item(f, v, i < hold, 16'(s));
      s = ($urandom_range(0, 30) == 0) ? 65535 : ((s >= 65535) ? 65535 : s + 1);
    end
  endtask

  initial begin
    sb = new();
    rst_n = 0;
    cfg_valid = 0; cfg_index = wbv_pkg::REG_TIMBRE; cfg_data = 0;
    in_valid = 0; freq_hz = 0; note_velocity = 0; gate = 0; since_onset = 0;
    burst_left = 0;
    sent = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // Directed: reset settings, each style, unused style, saturating fields.
    send_item(23'(110 << 8), 16'd32768, 1'b1, 16'd0);
    send_item(23'(110 << 8), 16'd32768, 1'b1, 16'd1);
    send_item(23'(110 << 8), 16'd32768, 1'b0, 16'd2);
    send_item(23'h7FFFFF, 16'hFFFF, 1'b1, 16'd0);
    send_item(23'd0, 16'd0, 1'b1, 16'hFFFF);
    drain();
    write_all(1'b1, wbv_pkg::PLUCK_PICK, 16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF);
    send_item(23'(55 << 8), 16'hFFFF, 1'b1, 16'd0);
    send_item(23'(55 << 8), 16'hFFFF, 1'b1, 16'd99);
    send_item(23'(55 << 8), 16'hFFFF, 1'b1, 16'd100);
    send_item(23'h7FFFFF, 16'h8001, 1'b0, 16'hFFFF);
    drain();
    write_all(1'b0, wbv_pkg::PLUCK_SLAP, 16'd0, 16'd0, 16'd32768, 24'd0);
    send_item(23'(220 << 8), 16'd20000, 1'b1, 16'd0);
    send_item(23'(220 << 8), 16'd20000, 1'b1, 16'd50);
    send_item(23'(220 << 8), 16'd20000, 1'b0, 16'd98);
    drain();
    write_all(1'b1, 2'd3, 16'd32768, 16'd32768, 16'd1, 24'd5825);
    send_item(23'(80 << 8), 16'd10000, 1'b1, 16'd0);
    send_item(23'(80 << 8), 16'd10000, 1'b1, 16'd1);
    send_item(23'(80 << 8), 16'd10000, 1'b0, 16'd0);
    send_item(23'h555555, 16'h5555, 1'b1, 16'hAAAA);
    send_item(23'h2AAAAA, 16'hAAAA, 1'b0, 16'h5555);

    for (int ph = 0; ph < 8; ph++) begin
      drain();
      write_all(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768)),
                ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768)),
                ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom),
                ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(2000, 12000)));
      for (int k = sent; sent < k + 200; ) begin
        if ($urandom_range(0, 9) == 0)
          send_item(23'($urandom), 16'($urandom), 1'($urandom_range(0, 1)),
                    ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3)));
        else
          play_note($urandom_range(1, 60), $urandom_range(0, 40));
        if (ph == 4 && sent > k + 100 && sent < k + 110) drain();
      end
    end

    drain();
    $display("Sent %0d note transactions, checked %0d samples across 12 settings phases,",
             sent, sb.checked);
    $display("with onsets of every style, releases, fret noise and saturating fields.");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
